// ===== hw/rtl/rbd_pkg.sv =====
// Package for the ring buffer deque: item, result and command types,
// operation and status codes. No dependencies.
package rbd_pkg;

    localparam logic [2:0] OP_CLEAR      = 3'd0;
    localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd2;
    localparam logic [2:0] OP_POP_FRONT  = 3'd3;
    localparam logic [2:0] OP_READ       = 3'd4;
    localparam logic [2:0] OP_DROP       = 3'd5;
    localparam logic [2:0] OP_TAKE       = 3'd6;
    localparam logic [2:0] OP_NOP        = 3'd7;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Entries in the command queue between front and back
    localparam int QDEPTH = 2;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] value;
        logic [7:0]  count;
    } in_item_t;

    typedef struct packed {
        logic [31:0] data;
        logic [7:0]  length;
        logic        empty_flag;
        logic [1:0]  status;
    } out_item_t;

    typedef struct packed {
        logic [2:0]  op;
        logic [31:0] value;
        logic [7:0]  count;
    } cmd_t;

endpackage

// ===== hw/rtl/rbd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/rbd_front.sv =====
// Front end of the deque: accepts items and classifies them into commands.
// Depends on rbd_pkg.
module rbd_front
    import rbd_pkg::*;
(
    input  logic     start,
    input  logic     queue_full,
    input  in_item_t item,
    output logic     busy,
    output logic     push,
    output cmd_t     cmd
);

    assign busy = queue_full;
    assign push = start && !queue_full;

    // Map unused codes to a no-op so the back end sees only known commands
    always_comb
    begin
        cmd.value = item.value;
        cmd.count = item.count;
        case (item.operation)
            OP_CLEAR, OP_PUSH_FRONT, OP_PUSH_BACK, OP_POP_FRONT,
            OP_READ, OP_DROP, OP_TAKE: cmd.op = item.operation;
            default:                   cmd.op = OP_NOP;
        endcase
    end

endmodule

// ===== hw/rtl/rbd_queue.sv =====
// Short command queue between the deque front and back ends.
// Depends on rbd_pkg.
module rbd_queue
    import rbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output logic not_empty,
    output logic full,
    output cmd_t head
);

    localparam int QAW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCW = $clog2(QDEPTH + 1);

    cmd_t           entry_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] cnt_reg, cnt_next;

    assign not_empty = cnt_reg != '0;
    assign full      = cnt_reg == QCW'(QDEPTH);
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== hw/rtl/rbd_back.sv =====
// Back end of the deque: executes commands against the pointers and the
// element store, and registers one result per command. Depends on rbd_pkg.
module rbd_back
    import rbd_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cmd_valid,
    input  cmd_t      cmd,
    output logic      cmd_pop,
    output logic      done,
    output out_item_t result
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int KW = (CW > 8) ? CW : 8;

    logic [PW-1:0] front_reg, front_next;
    logic [CW-1:0] fill_reg, fill_next;
    logic          wait_reg, wait_next;
    logic          done_reg, done_next;
    out_item_t     res_reg;

    logic                  we;
    logic [PW-1:0]         waddr;
    logic [PW-1:0]         raddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic [ELEM_WIDTH-1:0] rdata;
    logic                  rd_issue;
    logic [1:0]            status;
    logic [KW-1:0]         cnt_k;
    logic [KW-1:0]         fill_k;
    logic [KW-1:0]         len_k;
    logic [CW-1:0]         drop_n;
    logic [PW-1:0]         dec_front;
    logic [63:0]           wr_wide;
    logic [63:0]           rd_wide;

    // Base plus offset modulo DEPTH by one subtraction; exact while the sum stays below twice DEPTH
    function automatic logic [PW-1:0] wrap(input logic [PW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [CW:0] s;
        s = (CW+1)'(base) + (CW+1)'(off);
        if (s >= (CW+1)'(DEPTH))
        begin
            s = s - (CW+1)'(DEPTH);
        end
        return s[PW-1:0];
    endfunction

    assign cmd_pop   = cmd_valid && !wait_reg;
    assign cnt_k     = KW'(cmd.count);
    assign fill_k    = KW'(fill_reg);
    assign drop_n    = (cnt_k < fill_k) ? CW'(cnt_k) : fill_reg;
    assign dec_front = (front_reg == '0) ? PW'(DEPTH - 1) : front_reg - 1'b1;
    assign raddr     = wrap(front_reg, CW'(cnt_k));
    assign wr_wide   = 64'(cmd.value);
    assign wdata     = wr_wide[ELEM_WIDTH-1:0];
    assign rd_wide   = 64'(rdata);

    always_comb
    begin
        front_next = front_reg;
        fill_next  = fill_reg;
        we         = 1'b0;
        waddr      = dec_front;
        rd_issue   = 1'b0;
        status     = ST_OK;
        case (cmd.op)
            OP_CLEAR:
            begin
                front_next = '0;
                fill_next  = '0;
            end
            OP_PUSH_FRONT:
            begin
                if (fill_reg == CW'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    front_next = dec_front;
                    we         = 1'b1;
                    fill_next  = fill_reg + 1'b1;
                end
            end
            OP_PUSH_BACK:
            begin
                waddr = wrap(front_reg, fill_reg);
                if (fill_reg == CW'(DEPTH))
                begin
                    status = ST_FULL;
                end
                else
                begin
                    we        = 1'b1;
                    fill_next = fill_reg + 1'b1;
                end
            end
            OP_POP_FRONT:
            begin
                if (fill_reg == '0)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    front_next = wrap(front_reg, CW'(1));
                    fill_next  = fill_reg - 1'b1;
                end
            end
            OP_READ:
            begin
                if (cnt_k >= fill_k)
                begin
                    status = ST_RANGE;
                end
                else
                begin
                    rd_issue = 1'b1;
                end
            end
            OP_DROP:
            begin
                front_next = wrap(front_reg, drop_n);
                fill_next  = fill_reg - drop_n;
            end
            OP_TAKE:
            begin
                if (fill_k > cnt_k)
                begin
                    fill_next = CW'(cnt_k);
                end
            end
            default:
            begin
            end
        endcase
        if (!cmd_pop)
        begin
            front_next = front_reg;
            fill_next  = fill_reg;
            we         = 1'b0;
            rd_issue   = 1'b0;
        end
    end

    assign len_k     = KW'(fill_next);
    assign wait_next = rd_issue;
    assign done_next = (cmd_pop && !rd_issue) || wait_reg;

    rbd_ram #(
        .WIDTH (ELEM_WIDTH),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg <= '0;
            fill_reg  <= '0;
            wait_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            fill_reg  <= fill_next;
            wait_reg  <= wait_next;
            done_reg  <= done_next;
        end
    end

    // Hold length and status from the command; fill in read data in the cycle after
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            res_reg.data       <= '0;
            res_reg.length     <= len_k[7:0];
            res_reg.empty_flag <= (fill_next == '0);
            res_reg.status     <= status;
        end
        else if (wait_reg)
        begin
            res_reg.data <= rd_wide[31:0];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= CW'(DEPTH))
        else $error("fill count above capacity");

    a_front_bound: assert property (@(posedge clk) disable iff (!rst_n)
        front_reg <= PW'(DEPTH - 1))
        else $error("front pointer out of range");

    a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
        wait_reg |=> done_reg && !wait_reg)
        else $error("pending read did not produce a result");

    a_idle_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !cmd_pop |=> $stable(fill_reg) && $stable(front_reg))
        else $error("deque state changed without a command");

endmodule

// ===== hw/rtl/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: front end, command queue, back end.
// Depends on rbd_pkg, rbd_front, rbd_queue, rbd_back (and rbd_ram below it).
//
// Usage:
//   Drive item and raise start; the item is taken at a rising edge where
//   start is high and busy is low. Each item asks for one deque operation
//   and yields exactly one result, shown on result for one cycle with done
//   high. The receiver cannot stall; every done pulse must be consumed.
//   The back end registers the result of most operations directly; a read
//   inside the length first waits for the element store's registered read
//   port. Throughput: one item per cycle while busy is low, except that a
//   read holds the back end until its data returns; the two-entry command
//   queue absorbs that, and busy rises only while both entries are waiting.
//   Results come out in item order. Reset empties the deque (head at index
//   zero, length zero) and the command queue; store contents are not
//   cleared and are never read before being written.
module ring_buffer_deque
    import rbd_pkg::*;
#(
    parameter int DEPTH      = 128,
    parameter int ELEM_WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  in_item_t  item,
    output logic      done,
    output out_item_t result
);

    logic queue_full;
    logic queue_push;
    logic queue_pop;
    logic queue_not_empty;
    cmd_t front_cmd;
    cmd_t head_cmd;

    // Accept and classify
    rbd_front u_front (
        .start      (start),
        .queue_full (queue_full),
        .item       (item),
        .busy       (busy),
        .push       (queue_push),
        .cmd        (front_cmd)
    );

    // Decouple accept from execution
    rbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (queue_push),
        .push_cmd  (front_cmd),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .full      (queue_full),
        .head      (head_cmd)
    );

    // Execute against pointers and store, register the result
    rbd_back #(
        .DEPTH      (DEPTH),
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (queue_not_empty),
        .cmd       (head_cmd),
        .cmd_pop   (queue_pop),
        .done      (done),
        .result    (result)
    );

endmodule

// ===== test/ring_buffer_deque_test.sv =====
// Self-checking testbench for ring_buffer_deque: directed table, then phased random traffic.
// Depends on rbd_pkg and the ring_buffer_deque RTL. Carries its own deque predictor.
module ring_buffer_deque_test;
    import rbd_pkg::*;

    localparam int DEPTH         = 128;
    localparam int RANDOM_ITEMS  = 1450;
    localparam int SETTLE_CYCLES = 8;
    localparam int NUM_DIRECTED  = 24;

    typedef enum int {FILL_UP, DRAIN_DOWN, MIX_ALL} phase_t;

    // One directed row: the item, and a hand-typed result where it is obvious
    typedef struct packed {
        in_item_t  stim;
        logic      typed;
        out_item_t want;
    } step_row_t;

    // Fields: '{operation, value, count}, typed, '{data, length, empty_flag, status}
    localparam step_row_t DIRECTED [NUM_DIRECTED] = '{
        '{'{OP_POP_FRONT,  32'h0000_0000, 8'd0},   1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_RANGE}},
        '{'{OP_READ,       32'h0000_0000, 8'd0},   1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_RANGE}},
        '{'{OP_DROP,       32'h0000_0000, 8'd128}, 1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_OK}},
        '{'{OP_TAKE,       32'h0000_0000, 8'd0},   1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_OK}},
        '{'{OP_NOP,        32'hFFFF_FFFF, 8'd255}, 1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_OK}},
        '{'{OP_PUSH_BACK,  32'hFFFF_FFFF, 8'd255}, 1'b1, '{32'h0000_0000, 8'd1, 1'b0, ST_OK}},
        '{'{OP_PUSH_FRONT, 32'h0000_0000, 8'd0},   1'b1, '{32'h0000_0000, 8'd2, 1'b0, ST_OK}},
        '{'{OP_READ,       32'h0000_0000, 8'd0},   1'b1, '{32'h0000_0000, 8'd2, 1'b0, ST_OK}},
        '{'{OP_READ,       32'h0000_0000, 8'd1},   1'b1, '{32'hFFFF_FFFF, 8'd2, 1'b0, ST_OK}},
        '{'{OP_READ,       32'h0000_0000, 8'd2},   1'b1, '{32'h0000_0000, 8'd2, 1'b0, ST_RANGE}},
        '{'{OP_READ,       32'h0000_0000, 8'd255}, 1'b1, '{32'h0000_0000, 8'd2, 1'b0, ST_RANGE}},
        '{'{OP_PUSH_BACK,  32'hA5A5_A5A5, 8'd0},   1'b0, '0},
        '{'{OP_PUSH_FRONT, 32'h5A5A_5A5A, 8'd0},   1'b0, '0},
        '{'{OP_TAKE,       32'h0000_0000, 8'd255}, 1'b1, '{32'h0000_0000, 8'd4, 1'b0, ST_OK}},
        '{'{OP_TAKE,       32'h0000_0000, 8'd3},   1'b1, '{32'h0000_0000, 8'd3, 1'b0, ST_OK}},
        '{'{OP_READ,       32'h0000_0000, 8'd2},   1'b0, '0},
        '{'{OP_POP_FRONT,  32'h0000_0000, 8'd0},   1'b0, '0},
        '{'{OP_DROP,       32'h0000_0000, 8'd1},   1'b0, '0},
        '{'{OP_DROP,       32'h0000_0000, 8'd255}, 1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_OK}},
        // Head sits at index one here; push front steps it back to index zero
        '{'{OP_PUSH_FRONT, 32'h1234_5678, 8'd0},   1'b0, '0},
        '{'{OP_PUSH_BACK,  32'h8765_4321, 8'd0},   1'b0, '0},
        '{'{OP_READ,       32'h0000_0000, 8'd1},   1'b0, '0},
        '{'{OP_CLEAR,      32'h0000_0000, 8'd0},   1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_OK}},
        '{'{OP_READ,       32'h0000_0000, 8'd0},   1'b1, '{32'h0000_0000, 8'd0, 1'b1, ST_RANGE}}
    };

    // Operation mix per phase, indexed by operation code:
    // clear, push front, push back, pop front, read, drop, take, unused
    localparam int unsigned OP_WEIGHTS [3][8] = '{
        '{0, 35, 45,  3, 15,  0,  0, 2},
        '{2,  6,  6, 30, 24, 18, 10, 4},
        '{2, 20, 20, 15, 25,  8,  6, 4}
    };

    logic      clk;
    logic      rst_n;
    logic      start;
    logic      busy;
    in_item_t  item;
    logic      done;
    out_item_t result;

    // Predictor state: element store, head index, fill level
    logic [31:0] cells [DEPTH];
    logic [6:0]  head;
    logic [7:0]  fill;

    out_item_t   expect_q [$];
    int unsigned fail_count;
    int unsigned op_hits [8];
    int unsigned full_refusals;
    int unsigned range_misses;
    int unsigned full_reached;

    ring_buffer_deque u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .item   (item),
        .done   (done),
        .result (result)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Apply one item to the predicted deque and return the result it should give
    function automatic out_item_t predict_deque(input in_item_t it);
        out_item_t  res;
        logic [7:0] n;
        logic [6:0] slot;
        res = '0;
        res.status = ST_OK;
        op_hits[it.operation]++;
        case (it.operation)
            OP_CLEAR:
            begin
                head = '0;
                fill = '0;
            end
            OP_PUSH_FRONT:
            begin
                if (fill == DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    head        = head - 7'd1;
                    cells[head] = it.value;
                    fill        = fill + 8'd1;
                end
            end
            OP_PUSH_BACK:
            begin
                if (fill == DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    slot        = head + fill[6:0];
                    cells[slot] = it.value;
                    fill        = fill + 8'd1;
                end
            end
            OP_POP_FRONT:
            begin
                if (fill == 0)
                    res.status = ST_RANGE;
                else
                begin
                    head = head + 7'd1;
                    fill = fill - 8'd1;
                end
            end
            OP_READ:
            begin
                if (it.count >= fill)
                    res.status = ST_RANGE;
                else
                begin
                    slot     = head + it.count[6:0];
                    res.data = cells[slot];
                end
            end
            OP_DROP:
            begin
                n    = (it.count < fill) ? it.count : fill;
                head = head + n[6:0];
                fill = fill - n;
            end
            OP_TAKE:
            begin
                if (fill > it.count)
                    fill = it.count;
            end
            default:
            begin
            end
        endcase
        if (res.status == ST_FULL)
            full_refusals++;
        if (res.status == ST_RANGE)
            range_misses++;
        if (fill == DEPTH && (it.operation == OP_PUSH_FRONT || it.operation == OP_PUSH_BACK)
            && res.status == ST_OK)
            full_reached++;
        res.length     = fill;
        res.empty_flag = (fill == 0);
        return res;
    endfunction

    function automatic logic [2:0] pick_op(input phase_t ph);
        int unsigned roll;
        int unsigned acc;
        roll = $urandom_range(0, 99);
        acc  = 0;
        for (int k = 0; k < 8; k++)
        begin
            acc += OP_WEIGHTS[int'(ph)][k];
            if (roll < acc)
                return 3'(k);
        end
        return OP_NOP;
    endfunction

    // Mostly offsets around the current fill level, sometimes the field extremes
    function automatic logic [7:0] pick_count();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        case (roll)
            0:       return 8'd0;
            1:       return 8'd128;
            2:       return 8'd255;
            3:       return 8'($urandom_range(0, 255));
            default: return 8'($urandom_range(0, int'(fill) + 1));
        endcase
    endfunction

    function automatic logic [31:0] pick_value();
        int unsigned roll;
        roll = $urandom_range(0, 15);
        if (roll == 0)
            return 32'h0000_0000;
        if (roll == 1)
            return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    // Mostly back to back, some short gaps, a few long ones
    function automatic int pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 85)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    // Idle for gap cycles, present the item, hold it until taken, then predict
    task automatic deliver(input in_item_t it, input logic typed, input out_item_t want,
                           input int gap);
        out_item_t model;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        item  <= it;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        model = predict_deque(it);
        expect_q.push_back(typed ? want : model);
    endtask

    // Hold off the sender until every outstanding result has come back
    task automatic wait_drained();
        start <= 1'b0;
        do
            @(posedge clk);
        while (expect_q.size() != 0);
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, what, want, got);
            fail_count++;
        end
    endtask

    // Results cannot be held off; compare each one as it appears
    always @(posedge clk)
    begin
        out_item_t want;
        if (done === 1'b1)
        begin
            if (expect_q.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual %h", $time, result);
                fail_count++;
            end
            else
            begin
                want = expect_q.pop_front();
                check_field("data", want.data, result.data);
                check_field("length", 32'(want.length), 32'(result.length));
                check_field("empty flag", 32'(want.empty_flag), 32'(result.empty_flag));
                check_field("status", 32'(want.status), 32'(result.status));
            end
        end
    end

    initial
    begin
        int        sent;
        int        episode;
        int        span;
        phase_t    ph;
        logic      steady;
        in_item_t  it;

        rst_n         = 1'b0;
        start         = 1'b0;
        item          = '0;
        head          = '0;
        fill          = '0;
        fail_count    = 0;
        full_refusals = 0;
        range_misses  = 0;
        full_reached  = 0;
        foreach (op_hits[k])
            op_hits[k] = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table: empty-deque errors, extremes, wrap of the head
        for (int r = 0; r < NUM_DIRECTED; r++)
            deliver(DIRECTED[r].stim, DIRECTED[r].typed, DIRECTED[r].want, pick_gap());

        // Random phases; the first one is a long fill-up phase aimed at a full deque
        sent    = 0;
        episode = 0;
        while (sent < RANDOM_ITEMS)
        begin
            ph     = (episode == 0) ? FILL_UP : phase_t'($urandom_range(0, 2));
            span   = (episode == 0) ? 220 : $urandom_range(40, 200);
            steady = (episode != 0) && ($urandom_range(0, 3) == 0);
            for (int i = 0; i < span && sent < RANDOM_ITEMS; i++)
            begin
                it.operation = pick_op(ph);
                it.value     = pick_value();
                it.count     = pick_count();
                deliver(it, 1'b0, '0, steady ? 0 : pick_gap());
                sent++;
            end
            if (episode == 0 || $urandom_range(0, 2) == 0)
                wait_drained();
            episode++;
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Ran %0d directed and %0d random items in %0d phases; deque filled %0d times.",
                 NUM_DIRECTED, sent, episode, full_reached);
        $display("Refused pushes when full: %0d, out-of-range pops and reads: %0d, clears: %0d.",
                 full_refusals, range_misses, op_hits[OP_CLEAR]);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run
    initial
    begin
        #3000000;
        $display("Timeout with %0d results outstanding", expect_q.size());
        $display("CHECK FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/rbd_pkg.sv
hw/rtl/rbd_ram.sv
hw/rtl/rbd_front.sv
hw/rtl/rbd_queue.sv
hw/rtl/rbd_back.sv
hw/rtl/ring_buffer_deque.sv
test/ring_buffer_deque_test.sv
